### sv/c2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pkg
// shared types, register indexes and reset values of the chunky to planar
// converter
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int unsigned DimW       = 12;
  localparam int unsigned PlaneW     = 16;
  localparam int unsigned NumPlanes  = 4;
  localparam int unsigned PixelW     = 8;
  localparam int unsigned KeyW       = 9;
  localparam int unsigned PlaneCntW  = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned MAX_DIMENSION = 4095;

  localparam logic [DimW-1:0]      RowWidthRst    = 12'd320;
  localparam logic [DimW-1:0]      SourcePitchRst = 12'd0;
  localparam logic [DimW-1:0]      ImageHeightRst = 12'd200;
  localparam logic [KeyW-1:0]      KeyColourRst   = 9'h1FF;
  localparam logic [PlaneCntW-1:0] PlaneCountRst  = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_WIDTH    = 3'd0,
    REG_SOURCE_PITCH = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_KEY_COLOUR   = 3'd3,
    REG_PLANE_COUNT  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [DimW-1:0]      row_width;
    logic [DimW-1:0]      source_pitch;
    logic [DimW-1:0]      image_height;
    logic [KeyW-1:0]      key_colour;
    logic [PlaneCntW-1:0] plane_count;
  } cfg_t;

  typedef struct packed {
    logic [NumPlanes-1:0][PlaneW-1:0] planes;
    logic [PlaneW-1:0]                mask;
    logic [DimW-1:0]                  col;
    logic [DimW-1:0]                  row;
  } c2p_state_t;

  typedef struct packed {
    logic [NumPlanes-1:0][PlaneW-1:0] planes;
    logic [PlaneW-1:0]                mask;
    logic                             end_of_row;
    logic                             end_of_image;
  } group_t;

endpackage

### sv/c2p_pixel_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pixel_pack
// per-pixel step: merges one source byte into the group accumulators,
// builds the finished group and advances the column and row counters
// ----------------------------------------------------------------------------
module c2p_pixel_pack import c2p_pkg::*; #(
  parameter int unsigned MaxDimension = MAX_DIMENSION
) (
  input  cfg_t              cfg_i,
  input  c2p_state_t        state_i,
  input  logic [PixelW-1:0] pixel_i,
  output c2p_state_t        state_o,
  output logic              emit_o,
  output group_t            group_o
);

  localparam logic [16:0] MaxDimW = 17'(MaxDimension);

  logic [DimW-1:0]   width, pitch, height;
  logic [DimW:0]     col_plus, row_plus;
  logic [3:0]        pos;
  logic [PlaneW-1:0] bit_sel, pad;
  logic              visible, key_hit, eor, row_end;
  logic [NumPlanes-1:0][PlaneW-1:0] planes_upd;
  logic [PlaneW-1:0] mask_upd;

  always_comb begin
    // effective geometry
    width = (cfg_i.row_width == '0) ? DimW'(1) : cfg_i.row_width;
    if ({5'd0, width} > MaxDimW) begin
      width = MaxDimW[DimW-1:0];
    end
    pitch  = (cfg_i.source_pitch == '0) ? width : cfg_i.source_pitch;
    if (pitch < width) begin
      pitch = width;
    end
    height = (cfg_i.image_height == '0) ? DimW'(1) : cfg_i.image_height;

    col_plus = {1'b0, state_i.col} + 13'd1;
    row_plus = {1'b0, state_i.row} + 13'd1;
    visible  = state_i.col < width;
    pos      = state_i.col[3:0];
    bit_sel  = 16'h8000 >> pos;
    pad      = (16'h0001 << (4'd15 - pos)) - 16'h0001;
    key_hit  = !cfg_i.key_colour[KeyW-1] && (pixel_i == cfg_i.key_colour[PixelW-1:0]);

    // merge the pixel
    planes_upd = state_i.planes;
    mask_upd   = state_i.mask;
    if (visible) begin
      if (key_hit) begin
        mask_upd = state_i.mask | bit_sel;
      end else begin
        for (int p = 0; p < NumPlanes; p++) begin
          if (pixel_i[p] && (PlaneCntW'(p) < cfg_i.plane_count)) begin
            planes_upd[p] = state_i.planes[p] | bit_sel;
          end
        end
      end
    end

    eor     = col_plus == {1'b0, width};
    emit_o  = visible && ((pos == 4'd15) || eor);
    row_end = col_plus >= {1'b0, pitch};

    group_o.planes       = planes_upd;
    group_o.mask         = mask_upd | pad;
    group_o.end_of_row   = eor;
    group_o.end_of_image = eor && (row_plus >= {1'b0, height});

    // next state
    if (emit_o || row_end) begin
      state_o.planes = '0;
      state_o.mask   = '0;
    end else begin
      state_o.planes = planes_upd;
      state_o.mask   = mask_upd;
    end
    if (row_end) begin
      state_o.col = '0;
      state_o.row = (row_plus >= {1'b0, height}) ? '0 : row_plus[DimW-1:0];
    end else begin
      state_o.col = col_plus[DimW-1:0];
      state_o.row = state_i.row;
    end
  end

endmodule

### sv/chunky_to_planar_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunky_to_planar_converter_unit
// converts a stream of palette bytes into 16-pixel bitplane groups with a
// transparency mask
// ----------------------------------------------------------------------------
// The unit takes one source byte per clock cycle unless its input is
// stalled: every byte is captured in an input register, merged into the
// group accumulators by one short layer of logic (a shift, a key compare and
// four counter compares) and, when it closes a group, the group is loaded
// into the output register as the byte leaves the input register. A new byte
// is taken while a finished group still waits downstream; the unit only
// stalls its input when the byte held in the input register closes a group
// and the output register is still full and not taken. Source bytes past the
// visible width of a row are consumed and produce nothing. Configuration
// writes are taken in any cycle and must only be issued while the unit is idle.
module chunky_to_planar_converter_unit import c2p_pkg::*; #(
  parameter int unsigned MaxDimension = MAX_DIMENSION
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // source byte stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] pixel_byte
  // planar group stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [79:0]         m_axis_tdata,  // [15:0] plane_word_0, [31:16] plane_word_1,
                                             // [47:32] plane_word_2, [63:48] plane_word_3,
                                             // [79:64] transparency_mask
  output logic                m_axis_tlast,  // end_of_row
  output logic [0:0]          m_axis_tuser   // [0] end_of_image
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width    <= RowWidthRst;
      cfg_q.source_pitch <= SourcePitchRst;
      cfg_q.image_height <= ImageHeightRst;
      cfg_q.key_colour   <= KeyColourRst;
      cfg_q.plane_count  <= PlaneCountRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_WIDTH:    cfg_q.row_width    <= cfg_data_i;
        REG_SOURCE_PITCH: cfg_q.source_pitch <= cfg_data_i;
        REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i;
        REG_KEY_COLOUR:   cfg_q.key_colour   <= cfg_data_i[KeyW-1:0];
        REG_PLANE_COUNT:  cfg_q.plane_count  <= cfg_data_i[PlaneCntW-1:0];
        default: ;  // writes to unknown indexes are dropped
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input register
  logic              in_valid_q;
  logic [PixelW-1:0] in_byte_q;

  // accumulators and counters
  c2p_state_t state_q, state_d;
  logic       emit;
  group_t     group_d;

  // output register
  logic   out_valid_q;
  group_t out_group_q;

  logic advance;

  c2p_pixel_pack #(
    .MaxDimension (MaxDimension)
  ) u_pack (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .pixel_i (in_byte_q),
    .state_o (state_d),
    .emit_o  (emit),
    .group_o (group_d)
  );

  // the held byte moves on unless it closes a group and the output is blocked
  assign advance       = in_valid_q && (!emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_group_q <= group_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {out_group_q.mask, out_group_q.planes};
  assign m_axis_tlast    = out_group_q.end_of_row;
  assign m_axis_tuser[0] = out_group_q.end_of_image;

endmodule

### sv/c2p_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_checker
// port-level checks of the chunky to planar converter
// ----------------------------------------------------------------------------
module c2p_checker import c2p_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [79:0]         m_axis_tdata,
  input logic                m_axis_tlast,
  input logic [0:0]          m_axis_tuser
);

  // a stalled group stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output group dropped or changed while stalled");

  // the image ends only on a row end
  a_eoi_on_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("end of image without end of row");

  // the source is only held back by a blocked output
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("source stalled while output is free");

  // register writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind chunky_to_planar_converter_unit c2p_checker u_c2p_checker (.*);
